// ----- rtl/core/ers_pkg.sv -----
// Shared constants for the engine run state sequencer: widths, phase codes, timers, registers.
package ers_pkg;

  // Field and register widths
  localparam int SpeedW   = 14;
  localparam int TickW    = 10;
  localparam int CountW   = 16;
  localparam int PhaseW   = 3;
  localparam int AccelW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 14;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;
  localparam int NumTimer = 4;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_WAKEUP = 3'd0;
  localparam logic [PhaseW-1:0] PH_PRIMER = 3'd1;
  localparam logic [PhaseW-1:0] PH_STOP   = 3'd2;
  localparam logic [PhaseW-1:0] PH_CRANK  = 3'd3;
  localparam logic [PhaseW-1:0] PH_STALL  = 3'd4;
  localparam logic [PhaseW-1:0] PH_IDLE   = 3'd5;
  localparam logic [PhaseW-1:0] PH_CRUISE = 3'd6;
  localparam logic [PhaseW-1:0] PH_OVER   = 3'd7;

  // Acceleration class that counts as decelerating
  localparam logic [AccelW-1:0] ACCEL_DECEL = 2'd2;

  // Timeout timers
  localparam logic [1:0] T_FILL     = 2'd0;
  localparam logic [1:0] T_CRANKLIM = 2'd1;
  localparam logic [1:0] T_RUN      = 2'd2;
  localparam logic [1:0] T_STALL    = 2'd3;

  localparam logic [CountW-1:0] FILL_MS     = 16'd2000;
  localparam logic [CountW-1:0] CRANKLIM_MS = 16'd2000;
  localparam logic [CountW-1:0] RUN_MS      = 16'd3000;
  localparam logic [CountW-1:0] STALL_MS    = 16'd1500;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TICK_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IDLE_LOW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OVERSPEED   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OVER_HYST   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STOPPED     = 3'd5;

  // Configuration reset values
  localparam logic [TickW-1:0]  TICK_RST      = 10'd50;
  localparam logic [SpeedW-1:0] IDLE_LOW_RST  = 14'd800;
  localparam logic [SpeedW-1:0] IDLE_HIGH_RST = 14'd1500;
  localparam logic [SpeedW-1:0] OVER_RST      = 14'd9000;
  localparam logic [SpeedW-1:0] HYST_RST      = 14'd500;
  localparam logic [SpeedW-1:0] STOPPED_RST   = 14'd100;

endpackage

// ----- rtl/core/engine_run_state_sequencer.sv -----
// Engine run phase sequencer: per-tick phase machine with timeouts and a registered result.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | speed, pulse, primer done, accel class
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | phase, drives, pulses, stall count
//  cfg       | in  | cfg_we                       | cfg_index, cfg_data
//
// One tick is evaluated in the cycle it is transferred; its result is in the output
// register on the next cycle, so one tick per cycle is sustained while m_axis_tready is high.
// A new tick is taken whenever the output register is empty or being drained.
// Reset (rst, synchronous) returns the phase to wakeup, clears the timers and the
// stall count and loads the default thresholds.
module engine_run_state_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [13:0] shaft_rpm, [14] pulse_detected, [15] primer_done, [17:16] accel_class,
  // [23:18] zero
  input  logic [ers_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] phase, [3] pump_on, [4] injector_on, [5] primer_start, [6] crank_led,
  // [7] speed_clear, [23:8] stall_count
  output logic [ers_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [ers_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ers_pkg::CfgDataW-1:0] cfg_data
);
  import ers_pkg::*;

  // Configuration registers
  logic [TickW-1:0]  tick_period;
  logic [SpeedW-1:0] idle_low;
  logic [SpeedW-1:0] idle_high;
  logic [SpeedW-1:0] overspeed;
  logic [SpeedW-1:0] over_hyst;
  logic [SpeedW-1:0] stopped;

  // Sequencer state
  logic [PhaseW-1:0]   phase, phase_next;
  logic                pump, pump_next;
  logic                injector, injector_next;
  logic                led, led_next;
  logic [NumTimer-1:0] timer_en, timer_en_next;
  logic [CountW-1:0]   timer_cnt [NumTimer];
  logic [CountW-1:0]   timer_cnt_next [NumTimer];
  logic [CountW-1:0]   died_count, died_count_next;

  // Output register
  logic                out_valid;
  logic [OutDataW-1:0] out_data;

  // Per-tick working signals
  logic              accept;
  logic [SpeedW-1:0] speed;
  logic              pulse;
  logic              pdone;
  logic [AccelW-1:0] accel;
  logic [CountW-1:0] cnt_adv [NumTimer];
  logic              fill_en;
  logic              crank_fire;
  logic              stall_fire;
  logic              over_exit;
  logic              pstart;
  logic              sclear;
  logic              lost;

  assign speed = s_axis_tdata[13:0];
  assign pulse = s_axis_tdata[14];
  assign pdone = s_axis_tdata[15];
  assign accel = s_axis_tdata[17:16];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Saturating advance of every timer by one tick period
  always_comb begin
    for (int t = 0; t < NumTimer; t++) begin
      logic [CountW:0] sum;
      sum = {1'b0, timer_cnt[t]} + {{(CountW + 1 - TickW){1'b0}}, tick_period};
      cnt_adv[t] = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];
    end
  end

  // Overspeed exit: speed <= overspeed - hysteresis, without going negative
  assign over_exit = ({1'b0, speed} + {1'b0, over_hyst}) <= {1'b0, overspeed};

  // Phase transitions, following the short-circuit order of the timeout tests
  always_comb begin
    phase_next      = phase;
    pump_next       = pump;
    injector_next   = injector;
    led_next        = led;
    timer_en_next   = timer_en;
    died_count_next = died_count;
    for (int t = 0; t < NumTimer; t++) begin
      timer_cnt_next[t] = timer_cnt[t];
    end
    fill_en    = timer_en[T_FILL] || !pump;
    crank_fire = 1'b0;
    stall_fire = 1'b0;
    pstart     = 1'b0;
    sclear     = 1'b0;
    lost       = 1'b0;

    unique case (phase)
      PH_WAKEUP: begin
        if (!pump) begin
          pump_next              = 1'b1;
          timer_en_next[T_FILL]  = 1'b1;
        end
        if (fill_en) begin
          timer_cnt_next[T_FILL] = cnt_adv[T_FILL];
          if (cnt_adv[T_FILL] >= FILL_MS) begin
            timer_en_next[T_FILL] = 1'b0;
            injector_next         = 1'b1;
            pstart                = 1'b1;
            phase_next            = PH_PRIMER;
          end
        end
      end
      PH_PRIMER: begin
        if (pdone) begin
          injector_next = 1'b0;
          sclear        = 1'b1;
          led_next      = 1'b1;
          phase_next    = PH_STOP;
        end
      end
      PH_STOP: begin
        if (pulse) begin
          timer_en_next[T_CRANKLIM] = 1'b1;
          phase_next                = PH_CRANK;
        end
      end
      PH_CRANK: begin
        if (speed > idle_low) begin
          // Run timer is switched on before its test, so it always advances here
          timer_en_next[T_RUN]  = 1'b1;
          timer_cnt_next[T_RUN] = cnt_adv[T_RUN];
          if (cnt_adv[T_RUN] >= RUN_MS) begin
            timer_en_next[T_RUN]  = 1'b0;
            timer_cnt_next[T_RUN] = '0;
            led_next              = 1'b0;
            phase_next            = PH_IDLE;
          end
        end else begin
          if (accel != ACCEL_DECEL && timer_en[T_CRANKLIM]) begin
            timer_cnt_next[T_CRANKLIM] = cnt_adv[T_CRANKLIM];
            crank_fire                 = cnt_adv[T_CRANKLIM] >= CRANKLIM_MS;
          end
          if (accel == ACCEL_DECEL || crank_fire) begin
            timer_en_next[T_CRANKLIM]  = 1'b0;
            timer_cnt_next[T_CRANKLIM] = '0;
            timer_en_next[T_STALL]     = 1'b1;
            phase_next                 = PH_STALL;
          end
        end
      end
      PH_STALL: begin
        if (!(speed < stopped) && timer_en[T_STALL]) begin
          timer_cnt_next[T_STALL] = cnt_adv[T_STALL];
          stall_fire              = cnt_adv[T_STALL] >= STALL_MS;
        end
        if (speed < stopped || stall_fire) begin
          timer_en_next[T_STALL]  = 1'b0;
          timer_cnt_next[T_STALL] = '0;
          died_count_next         = died_count + 16'd1;
          sclear                  = 1'b1;
          led_next                = 1'b1;
          phase_next              = PH_STOP;
        end
      end
      PH_IDLE: begin
        if (speed > idle_high) begin
          phase_next = PH_CRUISE;
        end else if (speed <= idle_low) begin
          phase_next             = PH_STALL;
          timer_en_next[T_STALL] = 1'b1;
        end
        lost = !pulse;
      end
      PH_CRUISE: begin
        if (speed > overspeed) begin
          phase_next = PH_OVER;
        end else if (speed <= idle_high) begin
          phase_next = PH_IDLE;
        end
        lost = !pulse;
      end
      default: begin
        if (over_exit) begin
          phase_next = PH_CRUISE;
        end
        lost = !pulse;
      end
    endcase

    // Pulse loss in a running phase drops back to stop
    if (lost) begin
      sclear     = 1'b1;
      led_next   = 1'b1;
      phase_next = PH_STOP;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_RST;
      idle_low    <= IDLE_LOW_RST;
      idle_high   <= IDLE_HIGH_RST;
      overspeed   <= OVER_RST;
      over_hyst   <= HYST_RST;
      stopped     <= STOPPED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_PERIOD: tick_period <= cfg_data[TickW-1:0];
        REG_IDLE_LOW:    idle_low    <= cfg_data;
        REG_IDLE_HIGH:   idle_high   <= cfg_data;
        REG_OVERSPEED:   overspeed   <= cfg_data;
        REG_OVER_HYST:   over_hyst   <= cfg_data;
        REG_STOPPED:     stopped     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the sequencer state on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAKEUP;
      pump       <= 1'b0;
      injector   <= 1'b0;
      led        <= 1'b0;
      timer_en   <= '0;
      died_count <= '0;
      for (int t = 0; t < NumTimer; t++) begin
        timer_cnt[t] <= '0;
      end
    end else if (accept) begin
      phase      <= phase_next;
      pump       <= pump_next;
      injector   <= injector_next;
      led        <= led_next;
      timer_en   <= timer_en_next;
      died_count <= died_count_next;
      for (int t = 0; t < NumTimer; t++) begin
        timer_cnt[t] <= timer_cnt_next[t];
      end
    end
  end

  // Hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {died_count_next, sclear, led_next, pstart, injector_next, pump_next,
                   phase_next};
    end
  end

  // The injector is driven only while the primer phase lasts
  a_injector_primer: assert property (@(posedge clk) disable iff (rst)
    injector |-> phase == PH_PRIMER)
    else $error("injector on outside primer phase");

  // The stall count moves only when a stall ends
  a_died_in_stall: assert property (@(posedge clk) disable iff (rst)
    accept && died_count_next != died_count |-> phase == PH_STALL)
    else $error("stall count changed outside stall phase");

  // A primer start request always comes with entry to the primer phase
  a_pstart_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[5] |-> out_data[2:0] == PH_PRIMER && out_data[4])
    else $error("primer start without primer phase");

endmodule

// ----- test/ers_status_checker.sv -----
// Scoreboard for the engine run state sequencer: predicts the status of every tick and compares.
module ers_status_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // [13:0] shaft_rpm, [14] pulse_detected, [15] primer_done, [17:16] accel_class
  input  logic [ers_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] phase, [3] pump_on, [4] injector_on, [5] primer_start, [6] crank_led,
  // [7] speed_clear, [23:8] stall_count
  input  logic [ers_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [ers_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ers_pkg::CfgDataW-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import ers_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              pump;
    logic              injector;
    logic              primer_start;
    logic              crank_led;
    logic              speed_clear;
    logic [CountW-1:0] stall_count;
  } run_status_t;

  // Shadow copy of the thresholds
  logic [TickW-1:0]  tick_ms;
  logic [SpeedW-1:0] idle_low;
  logic [SpeedW-1:0] idle_high;
  logic [SpeedW-1:0] over_rpm;
  logic [SpeedW-1:0] over_hyst;
  logic [SpeedW-1:0] stop_rpm;

  // Shadow copy of the phase machine
  logic [PhaseW-1:0]   phase_q;
  logic                pump_q;
  logic                inj_q;
  logic                led_q;
  logic [NumTimer-1:0] tmr_en;
  logic [CountW-1:0]   tmr_cnt [NumTimer];
  logic [CountW-1:0]   died_q;

  run_status_t status_q[$];
  run_status_t want;
  run_status_t got;

  // Advance an enabled timer by one tick period, saturating, and test it
  function automatic logic timer_expired(input logic [1:0] t, input logic [CountW-1:0] limit);
    logic [CountW:0] sum;
    if (!tmr_en[t]) return 1'b0;
    sum = {1'b0, tmr_cnt[t]} + {{(CountW + 1 - TickW){1'b0}}, tick_ms};
    tmr_cnt[t] = sum[CountW] ? '1 : sum[CountW-1:0];
    return tmr_cnt[t] >= limit;
  endfunction

  function automatic void stop_timer(input logic [1:0] t);
    tmr_en[t] = 1'b0;
    tmr_cnt[t] = '0;
  endfunction

  // Step the phase machine by one tick and return the status it reports
  function automatic run_status_t advance_run(input logic [SpeedW-1:0] spd,
                                              input logic pulse, input logic pdone,
                                              input logic [AccelW-1:0] acc);
    logic        pstart;
    logic        sclear;
    logic        lost;
    logic        give_up;
    int          thr;
    run_status_t st;
    pstart = 1'b0;
    sclear = 1'b0;
    lost = 1'b0;
    case (phase_q)
      PH_WAKEUP: begin
        if (!pump_q) begin
          pump_q = 1'b1;
          tmr_en[T_FILL] = 1'b1;
        end
        if (timer_expired(T_FILL, FILL_MS)) begin
          tmr_en[T_FILL] = 1'b0;
          inj_q = 1'b1;
          pstart = 1'b1;
          phase_q = PH_PRIMER;
        end
      end
      PH_PRIMER: begin
        if (pdone) begin
          inj_q = 1'b0;
          sclear = 1'b1;
          led_q = 1'b1;
          phase_q = PH_STOP;
        end
      end
      PH_STOP: begin
        if (pulse) begin
          tmr_en[T_CRANKLIM] = 1'b1;
          phase_q = PH_CRANK;
        end
      end
      PH_CRANK: begin
        if (spd > idle_low) begin
          tmr_en[T_RUN] = 1'b1;
          if (timer_expired(T_RUN, RUN_MS)) begin
            stop_timer(T_RUN);
            led_q = 1'b0;
            phase_q = PH_IDLE;
          end
        end else begin
          // crank limit only advances when not decelerating
          give_up = (acc == ACCEL_DECEL);
          if (!give_up) give_up = timer_expired(T_CRANKLIM, CRANKLIM_MS);
          if (give_up) begin
            stop_timer(T_CRANKLIM);
            tmr_en[T_STALL] = 1'b1;
            phase_q = PH_STALL;
          end
        end
      end
      PH_STALL: begin
        give_up = (spd < stop_rpm);
        if (!give_up) give_up = timer_expired(T_STALL, STALL_MS);
        if (give_up) begin
          stop_timer(T_STALL);
          died_q = died_q + 1'b1;
          sclear = 1'b1;
          led_q = 1'b1;
          phase_q = PH_STOP;
        end
      end
      PH_IDLE: begin
        if (spd > idle_high) begin
          phase_q = PH_CRUISE;
        end else if (spd <= idle_low) begin
          phase_q = PH_STALL;
          tmr_en[T_STALL] = 1'b1;
        end
        lost = !pulse;
      end
      PH_CRUISE: begin
        if (spd > over_rpm) phase_q = PH_OVER;
        else if (spd <= idle_high) phase_q = PH_IDLE;
        lost = !pulse;
      end
      default: begin
        // exit threshold may go negative, then only lost pulses leave overspeed
        thr = int'(over_rpm) - int'(over_hyst);
        if (int'(spd) <= thr) phase_q = PH_CRUISE;
        lost = !pulse;
      end
    endcase
    if (lost) begin
      sclear = 1'b1;
      led_q = 1'b1;
      phase_q = PH_STOP;
    end
    st.phase = phase_q;
    st.pump = pump_q;
    st.injector = inj_q;
    st.primer_start = pstart;
    st.crank_led = led_q;
    st.speed_clear = sclear;
    st.stall_count = died_q;
    return st;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tick_ms = TICK_RST;
      idle_low = IDLE_LOW_RST;
      idle_high = IDLE_HIGH_RST;
      over_rpm = OVER_RST;
      over_hyst = HYST_RST;
      stop_rpm = STOPPED_RST;
      phase_q = PH_WAKEUP;
      pump_q = 1'b0;
      inj_q = 1'b0;
      led_q = 1'b0;
      tmr_en = '0;
      foreach (tmr_cnt[i]) tmr_cnt[i] = '0;
      died_q = '0;
      status_q.delete();
      pending <= 0;
    end else begin
      // predict on every accepted tick, with the thresholds held before this edge
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(advance_run(s_axis_tdata[13:0], s_axis_tdata[14],
                                       s_axis_tdata[15], s_axis_tdata[17:16]));
      end
      // track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_TICK_PERIOD: tick_ms = cfg_data[TickW-1:0];
          REG_IDLE_LOW:    idle_low = cfg_data;
          REG_IDLE_HIGH:   idle_high = cfg_data;
          REG_OVERSPEED:   over_rpm = cfg_data;
          REG_OVER_HYST:   over_hyst = cfg_data;
          REG_STOPPED:     stop_rpm = cfg_data;
          default: ;
        endcase
      end
      // compare every status transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[4], m_axis_tdata[5],
               m_axis_tdata[6], m_axis_tdata[7], m_axis_tdata[23:8]};
        if (status_q.size() == 0) begin
          $error("status transfer with no tick pending");
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("phase", int'(want.phase), int'(got.phase));
          check_field("pump_on", int'(want.pump), int'(got.pump));
          check_field("injector_on", int'(want.injector), int'(got.injector));
          check_field("primer_start", int'(want.primer_start), int'(got.primer_start));
          check_field("crank_led", int'(want.crank_led), int'(got.crank_led));
          check_field("speed_clear", int'(want.speed_clear), int'(got.speed_clear));
          check_field("stall_count", int'(want.stall_count), int'(got.stall_count));
        end
      end
      pending <= status_q.size();
    end
  end

endmodule

// ----- test/tb_engine_run_state_sequencer.sv -----
// Testbench top for the engine run state sequencer: clock, reset, ticks, register writes, verdict.
module tb_engine_run_state_sequencer;
  import ers_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AccelW-1:0] ACC_STABLE = 2'd0;
  localparam logic [AccelW-1:0] ACC_RISE   = 2'd1;
  localparam logic [AccelW-1:0] ACC_SPARE  = 2'd3;
  localparam int                SpeedMax   = 16383;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  fail_count;
  int                  pending;

  // thresholds as last written, used to aim the speeds
  int cfg_lo, cfg_hi, cfg_ov, cfg_hy, cfg_st;
  bit no_gaps;
  bit sink_no_stall;
  int sink_wait;
  int sink_draw;

  engine_run_state_sequencer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ers_status_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the status side for a random number of cycles after each transfer
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_draw = sink_no_stall ? 0 : $urandom_range(0, 6);
      sink_wait <= sink_draw;
      m_axis_tready <= (sink_draw == 0);
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else begin
      sink_wait <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int clamp_speed(input int x);
    if (x < 0) return 0;
    if (x > SpeedMax) return SpeedMax;
    return x;
  endfunction

  function automatic int near(input int x);
    return clamp_speed(x + int'($urandom_range(0, 4)) - 2);
  endfunction

  // Speeds that keep a running engine busy around its thresholds
  function automatic int run_speed();
    case ($urandom_range(0, 7))
      0: return near(cfg_lo);
      1: return near(cfg_hi);
      2: return near(cfg_ov);
      3: return near(cfg_ov - cfg_hy);
      4: return $urandom_range(0, SpeedMax);
      default: return $urandom_range(clamp_speed(cfg_lo + 1), SpeedMax);
    endcase
  endfunction

  // Offer one tick after a random gap and hold it until transferred
  task automatic send_tick(input int spd, input logic pulse, input logic pdone,
                           input logic [AccelW-1:0] acc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, acc, pdone, pulse, SpeedW'(spd)};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk);
  endtask

  task automatic configure(input int tk, input int lo, input int hi, input int ov,
                           input int hy, input int st);
    cfg_lo = lo;
    cfg_hi = hi;
    cfg_ov = ov;
    cfg_hy = hy;
    cfg_st = st;
    write_reg(REG_TICK_PERIOD, tk);
    write_reg(REG_IDLE_LOW, lo);
    write_reg(REG_IDLE_HIGH, hi);
    write_reg(REG_OVERSPEED, ov);
    write_reg(REG_OVER_HYST, hy);
    write_reg(REG_STOPPED, st);
    cfg_we <= 1'b0;
  endtask

  // Bursts of running, stalling and noise ticks, each with its own pacing
  task automatic random_phase(input int count);
    int left, burst, regime, spd;
    logic pulse;
    logic [AccelW-1:0] acc;
    left = count;
    while (left > 0) begin
      regime = $urandom_range(0, 9);
      burst = $urandom_range(4, 60);
      no_gaps = ($urandom_range(0, 5) == 0);
      sink_no_stall = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < burst && left > 0; k++) begin
        if (regime <= 6) begin
          spd = run_speed();
          pulse = ($urandom_range(0, 63) != 0);
          if ($urandom_range(0, 15) == 0) acc = ACCEL_DECEL;
          else acc = ($urandom_range(0, 1) != 0) ? ACC_RISE : ACC_SPARE;
          if ($urandom_range(0, 2) == 0) acc = ACC_STABLE;
        end else if (regime <= 7) begin
          spd = ($urandom_range(0, 1) != 0) ? $urandom_range(0, cfg_st)
                                            : $urandom_range(0, cfg_lo);
          pulse = 1'($urandom_range(0, 1));
          acc = ($urandom_range(0, 1) != 0) ? ACCEL_DECEL : AccelW'($urandom_range(0, 3));
        end else begin
          spd = $urandom_range(0, SpeedMax);
          pulse = 1'($urandom_range(0, 1));
          acc = AccelW'($urandom_range(0, 3));
        end
        send_tick(spd, pulse, 1'($urandom_range(0, 1)), acc);
        left--;
      end
    end
    no_gaps = 1'b0;
    sink_no_stall = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every phase with a long tick so the fill ends fast
    configure(1000, 800, 1500, 9000, 500, 100);
    send_tick(0, 1'b0, 1'b1, ACC_STABLE);        // wakeup: pump on, fill running
    send_tick(SpeedMax, 1'b1, 1'b1, ACC_SPARE);  // fill timeout: primer start
    send_tick(0, 1'b1, 1'b0, ACC_STABLE);        // primer held until done
    send_tick(0, 1'b0, 1'b1, ACC_STABLE);        // primer done: stop, injector off
    send_tick(5000, 1'b0, 1'b0, ACC_RISE);       // stop waits for pulses
    send_tick(0, 1'b1, 1'b0, ACC_STABLE);        // crank
    send_tick(SpeedMax, 1'b1, 1'b0, ACC_STABLE);
    send_tick(801, 1'b1, 1'b0, ACC_RISE);
    send_tick(900, 1'b0, 1'b0, ACCEL_DECEL);     // run timeout: idle
    send_tick(1500, 1'b1, 1'b0, ACC_STABLE);     // idle holds at its upper edge
    send_tick(1501, 1'b1, 1'b0, ACC_STABLE);     // cruise
    send_tick(1500, 1'b1, 1'b0, ACC_STABLE);     // back to idle
    send_tick(9000, 1'b1, 1'b0, ACC_STABLE);     // cruise
    send_tick(9001, 1'b1, 1'b0, ACC_STABLE);     // overspeed
    send_tick(8501, 1'b1, 1'b0, ACC_RISE);       // not below the exit threshold
    send_tick(8500, 1'b1, 1'b0, ACCEL_DECEL);    // cruise
    send_tick(SpeedMax, 1'b1, 1'b0, ACC_STABLE); // overspeed
    send_tick(SpeedMax, 1'b0, 1'b0, ACC_STABLE); // pulses lost: stop
    send_tick(0, 1'b1, 1'b0, ACC_STABLE);        // crank
    send_tick(800, 1'b1, 1'b0, ACCEL_DECEL);     // decelerating: stall
    send_tick(99, 1'b1, 1'b0, ACC_STABLE);       // stopped, stall counted
    send_tick(0, 1'b1, 1'b0, ACC_STABLE);        // crank
    send_tick(0, 1'b1, 1'b0, ACC_SPARE);         // class three is not decel
    send_tick(0, 1'b1, 1'b0, ACC_STABLE);        // crank limit: stall
    send_tick(100, 1'b1, 1'b0, ACC_STABLE);      // at threshold: stall timer runs
    send_tick(SpeedMax, 1'b1, 1'b0, ACC_STABLE); // stall timeout: stop
    wait_idle();

    // Random phases over several threshold settings
    configure(50, 800, 1500, 9000, 500, 100);
    random_phase(300);
    wait_idle();
    configure(1000, SpeedMax, SpeedMax, SpeedMax, 0, SpeedMax);
    random_phase(300);
    wait_idle();
    configure(0, 0, 0, 0, 0, 0);  // timeouts never fire
    random_phase(300);
    wait_idle();
    configure(1000, 20, 50, 100, SpeedMax, 10);  // negative overspeed exit
    random_phase(300);
    wait_idle();
    cfg_lo = $urandom_range(0, 3000);
    cfg_hi = cfg_lo + $urandom_range(0, 3000);
    configure($urandom_range(1, 1000), cfg_lo, cfg_hi, cfg_hi + $urandom_range(0, 8000),
              $urandom_range(0, 2000), $urandom_range(0, cfg_lo));
    random_phase(300);
    wait_idle();
    configure($urandom_range(1, 1000), $urandom_range(0, SpeedMax),
              $urandom_range(0, SpeedMax), $urandom_range(0, SpeedMax),
              $urandom_range(0, SpeedMax), $urandom_range(0, SpeedMax));
    random_phase(300);
    wait_idle();

    // Back-to-back stall cycles, each counted
    configure(1, 800, 1500, 9000, 500, 100);
    no_gaps = 1'b1;
    sink_no_stall = 1'b1;
    repeat (3) send_tick(0, 1'b0, 1'b0, ACCEL_DECEL);  // settle in stop
    for (int k = 0; k < 10; k++) begin
      send_tick($urandom_range(0, SpeedMax), 1'b1, 1'($urandom_range(0, 1)),
                AccelW'($urandom_range(0, 3)));
      send_tick($urandom_range(0, cfg_lo), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), ACCEL_DECEL);
      send_tick($urandom_range(0, cfg_st - 1), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), AccelW'($urandom_range(0, 3)));
    end
    wait_idle();
    repeat (5) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_engine_run_state_sequencer passed");
    end else begin
      $display("tb_engine_run_state_sequencer failed");
    end
    $finish;
  end

  initial begin
    #12ms;
    $display("tb_engine_run_state_sequencer failed");
    $finish;
  end

endmodule

// ----- engine_run_state_sequencer.f -----
rtl/core/ers_pkg.sv
rtl/core/engine_run_state_sequencer.sv
test/ers_status_checker.sv
test/tb_engine_run_state_sequencer.sv
